// ----- src/pl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_pkg
// Shared types and constants of the positional list engine: operation codes,
// status codes, controller states, the cell control group and field widths.
// ----------------------------------------------------------------------------
package pl_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_READ_POS  = 3'd6
  } op_t;

  localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SEND
  } state_t;

  // Broadcast to every cell in the accept cycle.
  typedef struct packed {
    logic ins;
    logic del;
    logic pick;
  } cell_ctl_t;

endpackage

// ----- src/pl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_cell
// One slot of the list. It holds a single value, takes its lower neighbor on
// an insert above the target slot, its upper neighbor on a delete at or above
// the target slot, and captures its own value when it is the target of a pick.
// ----------------------------------------------------------------------------
module pl_cell #(
  parameter int W  = 32,
  parameter int IW = 6,
  parameter int J  = 0
) (
  input  logic              clk,
  input  pl_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]     idx,
  input  logic [W-1:0]      new_val,
  input  logic [W-1:0]      lo_val,
  input  logic [W-1:0]      hi_val,
  output logic [W-1:0]      val,
  output logic [W-1:0]      pick
);

  logic at_idx;
  logic above;

  assign at_idx = (idx == IW'(J));
  assign above  = (IW'(J) > idx);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_idx) begin
        val <= new_val;
      end else if (above) begin
        val <= lo_val;
      end
    end else if (ctl.del && (at_idx || above)) begin
      val <= hi_val;
    end
    if (ctl.pick) begin
      pick <= at_idx ? val : '0;
    end
  end

endmodule

// ----- src/pl_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_tree
// Registered OR tree that gathers the one picked cell value. Every level, from
// the bottom one fed by the leaves up to the root, is a register.
// ----------------------------------------------------------------------------
module pl_tree #(
  parameter int W = 32,
  parameter int N = 64
) (
  input  logic         clk,
  input  logic [W-1:0] leaf_in [0:N-1],
  output logic [W-1:0] result
);

  localparam int LVL = $clog2(N);
  localparam int P   = 1 << LVL;

  logic [W-1:0] leaf [0:P-1];
  logic [W-1:0] node [1:P-1];

  genvar i;
  generate
    for (i = 0; i < P; i++) begin : g_leaf
      if (i < N) begin : g_used
        assign leaf[i] = leaf_in[i];
      end else begin : g_pad
        assign leaf[i] = '0;
      end
    end

    // Heap layout: node n has children 2n and 2n+1; indices from P up are leaves.
    for (i = 1; i < P; i++) begin : g_node
      if (2 * i >= P) begin : g_bottom
        always_ff @(posedge clk) begin
          node[i] <= leaf[2*i-P] | leaf[2*i+1-P];
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node[i] <= node[2*i] | node[2*i+1];
        end
      end
    end
  endgenerate

  assign result = node[1];

endmodule

// ----- src/positional_list_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of up to DEPTH signed values with positional insert,
// delete and read, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One word in gives one word out. The block takes a word only when idle; all
// cells compare their slot with the target and shift in the accept cycle, then
// the deleted or read value travels up a registered OR tree of clog2(DEPTH)
// levels while the controller steps through its reduce state, and the result is
// held until the output is taken; no new word is taken before then. The
// reported length is the list length after the operation, in 7 bits.
module positional_list_engine_top #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // opcode [2:0], position [9:3], value [41:10], zero fill above
  input  logic [pl_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status [1:0], length [8:2], data_value [40:9], zero fill above
  output logic [pl_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > pl_pkg::POS_W) ? CW : pl_pkg::POS_W) + 1;
  localparam int LVL  = $clog2(DEPTH);
  localparam int RCW  = $clog2(LVL + 1);

  pl_pkg::state_t state;
  pl_pkg::state_t state_next;
  logic [RCW-1:0] red_cnt;
  logic [RCW-1:0] red_cnt_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;

  logic [pl_pkg::STATUS_W-1:0] res_status;
  logic [pl_pkg::LEN_W-1:0]    res_len;
  logic                        res_keep;

  logic [pl_pkg::OPCODE_W-1:0] opcode;
  logic [pl_pkg::POS_W-1:0]    position;
  logic signed [pl_pkg::DATA_W-1:0] value;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] idx_x;
  logic            full;
  logic            empty;
  logic            accept;

  logic [pl_pkg::STATUS_W-1:0] dec_status;
  logic                        dec_keep;
  pl_pkg::cell_ctl_t           dec_ctl;
  pl_pkg::cell_ctl_t           ctl;

  logic [VALUE_WIDTH-1:0] new_val;
  logic [VALUE_WIDTH-1:0] cell_val  [0:DEPTH-1];
  logic [VALUE_WIDTH-1:0] cell_pick [0:DEPTH-1];
  logic [VALUE_WIDTH-1:0] picked;
  logic signed [pl_pkg::DATA_W-1:0] data_value;

  assign opcode   = s_tdata[2:0];
  assign position = s_tdata[9:3];
  assign value    = $signed(s_tdata[41:10]);

  assign pos_x   = CMPW'(position);
  assign cnt_x   = CMPW'(count);
  assign full    = (cnt_x == CMPW'(DEPTH));
  assign empty   = (count == '0);
  assign new_val = VALUE_WIDTH'(value);

  // Operation decode: status, target slot and cell controls.
  always_comb begin
    dec_status = pl_pkg::STAT_DONE;
    dec_keep   = 1'b0;
    dec_ctl    = '0;
    idx_x      = '0;
    count_next = count;
    case (pl_pkg::op_t'(opcode))
      pl_pkg::OP_INS_FRONT, pl_pkg::OP_INS_END: begin
        if (full) begin
          dec_status = pl_pkg::STAT_FULL;
        end else begin
          dec_ctl.ins = 1'b1;
          idx_x       = (pl_pkg::op_t'(opcode) == pl_pkg::OP_INS_END) ? cnt_x : '0;
          count_next  = count + CW'(1);
        end
      end
      pl_pkg::OP_INS_POS: begin
        if (full) begin
          dec_status = pl_pkg::STAT_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
          dec_status = pl_pkg::STAT_BAD;
        end else begin
          dec_ctl.ins = 1'b1;
          idx_x       = pos_x - CMPW'(1);
          count_next  = count + CW'(1);
        end
      end
      pl_pkg::OP_DEL_FRONT, pl_pkg::OP_DEL_END: begin
        if (empty) begin
          dec_status = pl_pkg::STAT_BAD;
        end else begin
          dec_ctl.del  = 1'b1;
          dec_ctl.pick = 1'b1;
          dec_keep     = 1'b1;
          idx_x        = (pl_pkg::op_t'(opcode) == pl_pkg::OP_DEL_END) ?
                         cnt_x - CMPW'(1) : '0;
          count_next   = count - CW'(1);
        end
      end
      pl_pkg::OP_DEL_POS, pl_pkg::OP_READ_POS: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          dec_status = pl_pkg::STAT_BAD;
        end else begin
          dec_ctl.pick = 1'b1;
          dec_keep     = 1'b1;
          idx_x        = pos_x - CMPW'(1);
          if (pl_pkg::op_t'(opcode) == pl_pkg::OP_DEL_POS) begin
            dec_ctl.del = 1'b1;
            count_next  = count - CW'(1);
          end
        end
      end
      default: begin
        dec_status = pl_pkg::STAT_BAD;
      end
    endcase
  end

  assign ctl = accept ? dec_ctl : '0;

  genvar j;
  generate
    for (j = 0; j < DEPTH; j++) begin : g_cell
      logic [VALUE_WIDTH-1:0] lo;
      logic [VALUE_WIDTH-1:0] hi;
      if (j == 0) begin : g_lo0
        assign lo = '0;
      end else begin : g_lo
        assign lo = cell_val[j-1];
      end
      if (j == DEPTH - 1) begin : g_hiN
        assign hi = '0;
      end else begin : g_hi
        assign hi = cell_val[j+1];
      end
      pl_cell #(
        .W  (VALUE_WIDTH),
        .IW (IW),
        .J  (j)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .idx     (idx_x[IW-1:0]),
        .new_val (new_val),
        .lo_val  (lo),
        .hi_val  (hi),
        .val     (cell_val[j]),
        .pick    (cell_pick[j])
      );
    end
  endgenerate

  pl_tree #(
    .W (VALUE_WIDTH),
    .N (DEPTH)
  ) u_tree (
    .clk     (clk),
    .leaf_in (cell_pick),
    .result  (picked)
  );

  // Controller: accept, wait for the tree to settle, then hold the result.
  always_comb begin
    state_next   = state;
    red_cnt_next = red_cnt;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    case (state)
      pl_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next   = pl_pkg::ST_REDUCE;
          red_cnt_next = '0;
        end
      end
      pl_pkg::ST_REDUCE: begin
        red_cnt_next = red_cnt + RCW'(1);
        if (red_cnt == RCW'(LVL - 1)) begin
          state_next = pl_pkg::ST_SEND;
        end
      end
      pl_pkg::ST_SEND: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = pl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pl_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pl_pkg::ST_IDLE;
      red_cnt <= '0;
      count   <= '0;
    end else begin
      state   <= state_next;
      red_cnt <= red_cnt_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= dec_status;
      res_len    <= pl_pkg::LEN_W'(count_next);
      res_keep   <= dec_keep;
    end
  end

  assign data_value = res_keep ? pl_pkg::DATA_W'($signed(picked)) : '0;

  assign m_tdata = {7'd0, data_value, res_len, res_status};

endmodule

// ----- verif/positional_list_engine_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_checker
// Watches both stream channels of the positional list engine. Every accepted
// input word is run through a local model of the ordered store, and the
// predicted status, length and value are queued. Every accepted output word
// is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module positional_list_engine_checker #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // opcode [2:0], position [9:3], value [41:10], zero fill above
  input  logic [pl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // status [1:0], length [8:2], data_value [40:9], zero fill above
  input  logic [pl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                             fail_count,
  output int                             pending,
  output int                             list_len,
  output int                             words_checked,
  output int                             full_rejects,
  output int                             bad_rejects
);

  import pl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
    logic [DATA_W-1:0]   data_value;
  } list_result_t;

  logic [DATA_W-1:0] cells [DEPTH];
  int                fill;
  int                fails;
  int                checked;
  int                fulls;
  int                bads;
  list_result_t      result_q [$];

  function automatic void open_gap(input int idx, input logic [DATA_W-1:0] val);
    for (int i = fill; i > idx; i--) cells[i] = cells[i-1];
    cells[idx] = val;
    fill++;
  endfunction

  function automatic logic [DATA_W-1:0] close_gap(input int idx);
    logic [DATA_W-1:0] taken;
    taken = cells[idx];
    for (int i = idx; i + 1 < fill; i++) cells[i] = cells[i+1];
    fill--;
    return taken;
  endfunction

  function automatic list_result_t apply_word(input logic [OPCODE_W-1:0] op,
                                              input logic [POS_W-1:0]    pos,
                                              input logic [DATA_W-1:0]   val);
    list_result_t res;
    res = '0;
    res.status = STAT_DONE;
    case (op_t'(op))
      OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
        // A full store wins over a bad position.
        if (fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else if (op_t'(op) == OP_INS_FRONT) begin
          open_gap(0, val);
        end else if (op_t'(op) == OP_INS_END) begin
          open_gap(fill, val);
        end else if (pos < 1 || pos > fill + 1) begin
          res.status = STAT_BAD;
        end else begin
          open_gap(pos - 1, val);
        end
      end
      OP_DEL_FRONT: begin
        if (fill == 0) res.status = STAT_BAD;
        else res.data_value = close_gap(0);
      end
      OP_DEL_END: begin
        if (fill == 0) res.status = STAT_BAD;
        else res.data_value = close_gap(fill - 1);
      end
      OP_DEL_POS: begin
        if (pos < 1 || pos > fill) res.status = STAT_BAD;
        else res.data_value = close_gap(pos - 1);
      end
      OP_READ_POS: begin
        if (pos < 1 || pos > fill) res.status = STAT_BAD;
        else res.data_value = cells[pos - 1];
      end
      default: res.status = STAT_BAD;
    endcase
    res.length = LEN_W'(fill);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst) begin
      fill    = 0;
      fails   = 0;
      checked = 0;
      fulls   = 0;
      bads    = 0;
      result_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status     = m_tdata[1:0];
        got.length     = m_tdata[8:2];
        got.data_value = m_tdata[40:9];
        if (result_q.size() == 0) begin
          $error("output word with no prediction waiting: %h", m_tdata);
          fails++;
        end else begin
          want = result_q.pop_front();
          checked++;
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.length != want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            fails++;
          end
          if (got.data_value != want.data_value) begin
            $error("data_value: expected %0d, got %0d",
                   $signed(want.data_value), $signed(got.data_value));
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_word(s_tdata[2:0], s_tdata[9:3], s_tdata[41:10]);
        if (want.status == STAT_FULL) fulls++;
        if (want.status == STAT_BAD) bads++;
        result_q.push_back(want);
      end
    end
    fail_count    <= fails;
    pending       <= result_q.size();
    list_len      <= fill;
    words_checked <= checked;
    full_rejects  <= fulls;
    bad_rejects   <= bads;
  end

endmodule

// ----- verif/positional_list_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top_tb
// Drives the positional list engine with a directed run over empty, bad
// position and undefined opcode cases, then random phases that fill, drain
// and churn the store, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module positional_list_engine_top_tb;

  import pl_pkg::*;

  localparam int LIST_DEPTH     = 64;
  localparam int RANDOM_WORDS   = 850;
  localparam int QUIET_WORDS    = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [OPCODE_W-1:0] OP_UNDEFINED = 3'd7;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // opcode [2:0], position [9:3], value [41:10], zero fill above
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // status [1:0], length [8:2], data_value [40:9], zero fill above
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic src_idle_en = 1'b0;
  logic snk_idle_en = 1'b0;
  int   snk_hold    = 0;
  int   stall_cycles = 0;

  int fail_count;
  int pending;
  int list_len;
  int words_checked;
  int full_rejects;
  int bad_rejects;

  positional_list_engine_top #(
    .DEPTH      (LIST_DEPTH),
    .VALUE_WIDTH(DATA_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  positional_list_engine_checker #(
    .DEPTH(LIST_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .list_len     (list_len),
    .words_checked(words_checked),
    .full_rejects (full_rejects),
    .bad_rejects  (bad_rejects)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_hold <= 0;
    end else if (snk_hold > 0) begin
      snk_hold <= snk_hold - 1;
      m_tready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
      snk_hold <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("positional_list_engine_top_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(input mix_t mix);
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   val;
    int                  ins_pct;
    int                  roll;
    case (mix)
      MIX_FILL:  ins_pct = 85;
      MIX_DRAIN: ins_pct = 15;
      default:   ins_pct = 50;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 2) op = OP_UNDEFINED;
    else if (roll < 2 + ins_pct * 98 / 100)
      op = OPCODE_W'($urandom_range(OP_INS_FRONT, OP_INS_POS));
    else op = OPCODE_W'($urandom_range(OP_DEL_FRONT, OP_READ_POS));
    // Mostly positions near the current length, so that most are legal.
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, list_len + 1));
    else pos = POS_W'($urandom_range(0, 127));
    case ($urandom_range(0, 19))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      2:       val = 32'h0000_0000;
      3:       val = 32'hffff_ffff;
      default: val = $urandom;
    endcase
    send_word(op, pos, val);
  endtask

  initial begin
    int   sent;
    int   phase_len;
    mix_t mix;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store, undefined opcode and insert positions out of range, then inserts that build a five-entry list.
    send_word(OP_DEL_FRONT, 7'd0, 32'h0);
    send_word(OP_DEL_END, 7'd0, 32'h0);
    send_word(OP_DEL_POS, 7'd1, 32'h0);
    send_word(OP_READ_POS, 7'd0, 32'h0);
    send_word(OP_UNDEFINED, 7'd127, 32'hffff_ffff);
    send_word(OP_INS_POS, 7'd0, 32'h1234_5678);
    send_word(OP_INS_POS, 7'd2, 32'h1234_5678);
    send_word(OP_INS_POS, 7'd1, 32'h7fff_ffff);
    send_word(OP_INS_FRONT, 7'd0, 32'h8000_0000);
    send_word(OP_INS_END, 7'd127, 32'h0000_0000);
    send_word(OP_INS_POS, 7'd4, 32'hffff_ffff);
    send_word(OP_INS_POS, 7'd2, 32'h5a5a_5a5a);
    // Reads and deletes at and past the end of a five-entry list, then deletes at the middle, front and end.
    send_word(OP_READ_POS, 7'd5, 32'h0);
    send_word(OP_READ_POS, 7'd6, 32'h0);
    send_word(OP_READ_POS, 7'd127, 32'h0);
    send_word(OP_DEL_POS, 7'd127, 32'h0);
    send_word(OP_DEL_POS, 7'd3, 32'h0);
    send_word(OP_READ_POS, 7'd1, 32'h0);
    send_word(OP_DEL_FRONT, 7'd0, 32'h0);
    send_word(OP_DEL_END, 7'd0, 32'h0);
    send_word(OP_UNDEFINED, 7'd0, 32'h0);
    send_word(OP_READ_POS, 7'd1, 32'h0);

    // The first phase is long enough to reach a full store from near empty.
    sent      = 0;
    mix       = MIX_FILL;
    phase_len = 150;
    while (sent < RANDOM_WORDS) begin
      if (sent >= RANDOM_WORDS - QUIET_WORDS) begin
        src_idle_en = 1'b0;
        snk_idle_en <= 1'b0;
      end else begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en <= ($urandom_range(0, 3) != 0);
      end
      for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++) begin
        // The last words of the run go out with no idling on either side.
        if (sent == RANDOM_WORDS - QUIET_WORDS) begin
          src_idle_en = 1'b0;
          snk_idle_en <= 1'b0;
        end
        send_random(mix);
        sent++;
      end
      mix       = mix_t'($urandom_range(MIX_FILL, MIX_EVEN));
      phase_len = $urandom_range(40, 160);
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words over directed and fill, drain and mixed phases.",
             words_checked);
    $display("Rejections seen: %0d on a full store, %0d on a bad position or empty store.",
             full_rejects, bad_rejects);
    if (fail_count == 0) begin
      $display("positional_list_engine_top_tb OK");
    end else begin
      $display("positional_list_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- positional_list_engine_top.f -----
src/pl_pkg.sv
src/pl_cell.sv
src/pl_tree.sv
src/positional_list_engine_top.sv
verif/positional_list_engine_checker.sv
verif/positional_list_engine_top_tb.sv
